>>> rtl/pka_pkg.sv
// ----------------------------------------------------------------------------
// pka_pkg
// Shared types and constants for the protection key allocator: operation and
// status codes, configuration register indexes, item and state structs.
// ----------------------------------------------------------------------------
package pka_pkg;

  localparam int unsigned MapWidth    = 16;
  localparam int unsigned KeyWidth    = 4;
  localparam int unsigned RightsWidth = 32;
  localparam int unsigned ShiftWidth  = 5;

  localparam logic [MapWidth-1:0]    UsedMapReset       = 16'h0001;
  localparam logic                   FeatureResetValue  = 1'b1;
  localparam logic [RightsWidth-1:0] InitRightsReset    = 32'h5555_5554;

  // Per-key rights flags: access-disable at bit 2k, write-disable at 2k+1
  localparam logic [1:0] FlagNoAccess = 2'b01;
  localparam logic [1:0] FlagNoWrite  = 2'b10;
  localparam logic [1:0] FlagBoth     = FlagNoAccess | FlagNoWrite;

  typedef enum logic [1:0] {
    OP_ALLOC    = 2'd0,
    OP_FREE     = 2'd1,
    OP_SET_PROT = 2'd2,
    OP_SETUP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_UNSUPPORTED = 2'd1,
    STATUS_NO_FREE_KEY = 2'd2,
    STATUS_INVALID_KEY = 2'd3
  } status_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_FEATURE_ENABLED = 1'b0,
    CFG_INITIAL_RIGHTS  = 1'b1
  } cfg_index_t;

  typedef struct packed {
    op_t                 opcode;
    logic [KeyWidth-1:0] key;
    logic [1:0]          prot_flags;
  } in_item_t;

  typedef struct packed {
    status_t                status;
    logic [KeyWidth-1:0]    granted_key;
    logic                   reg_write;
    logic [RightsWidth-1:0] reg_value;
  } out_item_t;

  typedef struct packed {
    logic [MapWidth-1:0]    used_map;
    logic [RightsWidth-1:0] saved_rights;
    logic [RightsWidth-1:0] register_cache;
  } pka_state_t;

endpackage

>>> rtl/pka_core.sv
// ----------------------------------------------------------------------------
// pka_core
// Single-pass operation logic: lowest-free-key search, rights field update,
// register write filtering, and next state for one item.
// ----------------------------------------------------------------------------
module pka_core import pka_pkg::*; #(
  parameter int unsigned KEY_COUNT = 16
) (
  input  in_item_t                item,
  input  pka_state_t              state,
  input  logic                    feature_enabled,
  input  logic [RightsWidth-1:0]  initial_rights,
  output out_item_t               result,
  output pka_state_t              state_next
);

  localparam int unsigned KeyLimit = (KEY_COUNT < MapWidth) ? KEY_COUNT : MapWidth;
  localparam logic [MapWidth-1:0] LimitMask = MapWidth'((33'd1 << KeyLimit) - 33'd1);

  logic [MapWidth-1:0]    free_map;
  logic                   found;
  logic [KeyWidth-1:0]    alloc_key;
  logic                   key_ok;
  logic [ShiftWidth-1:0]  shamt;
  logic [RightsWidth-1:0] field_mask;
  logic [RightsWidth-1:0] write_value;
  logic                   write_intent;
  logic                   do_write;

  // Find the lowest free key inside the managed range
  always_comb begin
    free_map  = ~state.used_map & LimitMask;
    found     = 1'b0;
    alloc_key = '0;
    for (int i = MapWidth - 1; i >= 0; i--) begin
      if (free_map[i]) begin
        found     = 1'b1;
        alloc_key = KeyWidth'(i);
      end
    end
  end

  assign key_ok     = (32'(item.key) < KeyLimit);
  assign shamt      = {item.key, 1'b0};
  assign field_mask = RightsWidth'(FlagBoth) << shamt;

  // Decode the operation and build the next state
  always_comb begin
    state_next   = state;
    result       = '0;
    result.status = STATUS_OK;
    write_value  = state.register_cache;
    write_intent = 1'b0;
    case (item.opcode)
      OP_ALLOC: begin
        if (!feature_enabled) begin
          result.status = STATUS_UNSUPPORTED;
        end else if (!found) begin
          result.status = STATUS_NO_FREE_KEY;
        end else begin
          result.granted_key  = alloc_key;
          state_next.used_map = state.used_map | (MapWidth'(1) << alloc_key);
        end
      end
      OP_FREE: begin
        if (item.key == '0 || !key_ok) begin
          result.status = STATUS_INVALID_KEY;
        end else begin
          state_next.saved_rights = (state.saved_rights & ~field_mask) |
                                    (RightsWidth'(FlagNoAccess) << shamt);
          write_value  = state_next.saved_rights;
          write_intent = 1'b1;
          state_next.used_map = state.used_map & ~(MapWidth'(1) << item.key);
        end
      end
      OP_SET_PROT: begin
        if (!key_ok) begin
          result.status = STATUS_INVALID_KEY;
        end else begin
          state_next.saved_rights = (state.saved_rights & ~field_mask) |
                                    (RightsWidth'(item.prot_flags) << shamt);
          write_value  = state_next.saved_rights;
          write_intent = 1'b1;
        end
      end
      OP_SETUP: begin
        if (!feature_enabled) begin
          result.status = STATUS_UNSUPPORTED;
        end else begin
          write_value  = initial_rights;
          write_intent = 1'b1;
        end
      end
      default: begin
        result.status = STATUS_OK;
      end
    endcase

    // Drop the write when disabled or when the cache already holds the value
    do_write = write_intent && feature_enabled && (write_value != state.register_cache);
    result.reg_write = do_write;
    result.reg_value = do_write ? write_value : state.register_cache;
    state_next.register_cache = result.reg_value;
  end

endmodule

>>> rtl/protection_key_allocator.sv
// ----------------------------------------------------------------------------
// protection_key_allocator
// Path: the accept edge loads the input register; the result register loads
// from it once the output is free or being taken.
// Throughput: one item per cycle unless the output stalls, set by the single
// pass through the key search and rights update between the two registers.
// Reset: key 0 marked used, rights and cache cleared, config at defaults.
// ----------------------------------------------------------------------------
module protection_key_allocator import pka_pkg::*; #(
  parameter int unsigned KEY_COUNT = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  cfg_index_t             cfg_index,
  input  logic [RightsWidth-1:0] cfg_data
);

  localparam int unsigned KeyLimit = (KEY_COUNT < MapWidth) ? KEY_COUNT : MapWidth;

  logic                   feature_enabled;
  logic [RightsWidth-1:0] initial_rights;
  pka_state_t             state;
  pka_state_t             state_next;
  logic                   stage_valid;
  in_item_t               stage_item;
  out_item_t              result;
  logic                   advance;

  assign cfg_ready = 1'b1;
  assign advance   = stage_valid && (!out_valid || out_ready);
  assign in_ready  = !stage_valid || advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      feature_enabled <= FeatureResetValue;
      initial_rights  <= InitRightsReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FEATURE_ENABLED: feature_enabled <= cfg_data[0];
        CFG_INITIAL_RIGHTS:  initial_rights  <= cfg_data;
        default:             initial_rights  <= initial_rights;
      endcase
    end
  end

  // Hold the accepted item until it can move to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_item <= in_data;
    end
  end

  pka_core #(
    .KEY_COUNT (KEY_COUNT)
  ) u_core (
    .item            (stage_item),
    .state           (state),
    .feature_enabled (feature_enabled),
    .initial_rights  (initial_rights),
    .result          (result),
    .state_next      (state_next)
  );

  // Advance state together with the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.used_map       <= UsedMapReset;
      state.saved_rights   <= '0;
      state.register_cache <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  // Key 0 stays reserved
  assert property (@(posedge clk) disable iff (rst) state.used_map[0])
    else $error("key 0 released");

  // Keys beyond the managed range are never marked used
  assert property (@(posedge clk) disable iff (rst)
    (32'(state.used_map) >> KeyLimit) == 32'd0)
    else $error("key beyond limit marked used");

  // A pending result always reports the cache that it left behind
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.reg_value == state.register_cache)
    else $error("result value and register cache disagree");

  // A register write or a granted key only comes with ok status
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.reg_write || out_data.granted_key != '0)
      |-> out_data.status == STATUS_OK)
    else $error("write or grant with failing status");

  // State holds while a stalled result waits to be taken
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(state))
    else $error("state changed under a stalled result");
`endif

endmodule
